@@ sv/bza_pkg.sv @@
// Types and constants shared by the balanced zone assigner modules.
`default_nettype none

package bza_pkg;

  localparam int ZONE_W     = 3;
  localparam int ZC_W       = 4;
  localparam int POS_W      = 6;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_ZONE_COUNT   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEEP_CURRENT = 1'd1;

  typedef struct packed {
    logic [ZONE_W-1:0] cur_zone;
    logic              zone_known;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  item_position;
    logic [ZONE_W-1:0] assigned_zone;
    logic              last_result;
  } out_item_t;

  // one stored item: zone plus "needs placement" flag
  typedef struct packed {
    logic              unplaced;
    logic [ZONE_W-1:0] zone;
  } mem_entry_t;

  localparam int MEM_W = $bits(mem_entry_t);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_KEEP,
    MODE_FILL,
    MODE_MOVE
  } mode_t;

  typedef struct packed {
    logic  load_we;
    logic  load_last;
    logic  rd_issue;
    logic  scan_clr;
    mode_t mode;
    logic  out_load;
    logic  grp_done;
  } bza_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic pend_vld;
    logic pend_hit;
    logic pend_last;
    logic balanced;
    logic out_free;
  } bza_status_t;

endpackage

`default_nettype wire

@@ sv/bza_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bza_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/bza_ctrl.sv @@
// Sequencer for load, keep/fill passes, balancing moves and result output.
`default_nettype none

module bza_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output      logic                 in_ready,
  input  wire bza_pkg::bza_status_t st,
  output      bza_pkg::bza_cmd_t    cmd
);
  import bza_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_KEEP,
    S_FILL,
    S_BAL,
    S_MOVE,
    S_OUT_RD,
    S_OUT_WR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mode  = MODE_IDLE;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_we = 1'b1;
          if (in_last) begin
            cmd.load_last = 1'b1;
            cmd.scan_clr  = 1'b1;
            state_nxt     = S_KEEP;
          end
        end
      end
      S_KEEP: begin
        cmd.mode     = MODE_KEEP;
        cmd.rd_issue = !st.scan_end;
        if (st.scan_end && !st.pend_vld) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_FILL;
        end
      end
      S_FILL: begin
        cmd.mode     = MODE_FILL;
        cmd.rd_issue = !st.scan_end;
        if (st.scan_end && !st.pend_vld) begin
          state_nxt = S_BAL;
        end
      end
      S_BAL: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = st.balanced ? S_OUT_RD : S_MOVE;
      end
      S_MOVE: begin
        // scan from the first item until one sits in the fullest zone
        cmd.mode = MODE_MOVE;
        if (st.pend_vld && st.pend_hit) begin
          state_nxt = S_BAL;
        end else if (st.scan_end && !st.pend_vld) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_OUT_RD;
        end else begin
          cmd.rd_issue = !st.scan_end;
        end
      end
      S_OUT_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_OUT_WR;
      end
      S_OUT_WR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.pend_last) begin
            cmd.grp_done = 1'b1;
            state_nxt    = S_LOAD;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/bza_dp.sv @@
// Datapath: item store, zone tallies, min/max search, config and output registers.
`default_nettype none

module bza_dp #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_ZONES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bza_pkg::in_item_t                 in_data,
  input  wire logic                              cfg_we,
  input  wire logic [bza_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [bza_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire bza_pkg::bza_cmd_t                 cmd,
  output      bza_pkg::bza_status_t              st,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      bza_pkg::out_item_t                out_data
);
  import bza_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [ZC_W-1:0] zone_count_r;
  logic            keep_current_r;
  logic [ZC_W-1:0] zc_r;
  logic            keep_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   scan_r;
  logic [AW-1:0]   pend_addr_r;
  logic            pend_vld_r;
  logic [CW-1:0]   tally_r   [MAX_ZONES];
  logic [CW-1:0]   tally_nxt [MAX_ZONES];
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            room;
  logic [ZC_W-1:0] zc_eff;
  mem_entry_t      rd_ent;
  logic [MEM_W-1:0] rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mem_entry_t      mem_wdata;
  logic            ph_we;
  mem_entry_t      ph_wdata;
  logic [ZONE_W-1:0] lo_zone, hi_zone;
  logic [CW-1:0]   lo_cnt, hi_cnt;
  logic            keep_ok;
  logic            inc_en, dec_en;
  logic [ZONE_W-1:0] inc_zone, dec_zone;

  assign room   = (cnt_r < CW'(MAX_ITEMS));
  assign rd_ent = mem_entry_t'(rdata);

  always_comb begin
    if (zone_count_r == '0) begin
      zc_eff = ZC_W'(1);
    end else if (zone_count_r > ZC_W'(MAX_ZONES)) begin
      zc_eff = ZC_W'(MAX_ZONES);
    end else begin
      zc_eff = zone_count_r;
    end
  end

  // lowest-index argmin and argmax over the active zones
  always_comb begin
    lo_zone = '0;
    hi_zone = '0;
    lo_cnt  = tally_r[0];
    hi_cnt  = tally_r[0];
    for (int z = 1; z < MAX_ZONES; z++) begin
      if (ZC_W'(z) < zc_r) begin
        if (tally_r[z] < lo_cnt) begin
          lo_cnt  = tally_r[z];
          lo_zone = ZONE_W'(z);
        end
        if (tally_r[z] > hi_cnt) begin
          hi_cnt  = tally_r[z];
          hi_zone = ZONE_W'(z);
        end
      end
    end
  end

  assign keep_ok = keep_r && !rd_ent.unplaced && ({1'b0, rd_ent.zone} < zc_r);

  always_comb begin
    ph_we    = 1'b0;
    ph_wdata = rd_ent;
    inc_en   = 1'b0;
    dec_en   = 1'b0;
    inc_zone = rd_ent.zone;
    dec_zone = hi_zone;
    unique case (cmd.mode)
      MODE_KEEP: begin
        if (pend_vld_r) begin
          if (keep_ok) begin
            inc_en = 1'b1;
          end else begin
            ph_we             = 1'b1;
            ph_wdata.unplaced = 1'b1;
          end
        end
      end
      MODE_FILL: begin
        if (pend_vld_r && rd_ent.unplaced) begin
          ph_we             = 1'b1;
          ph_wdata.unplaced = 1'b0;
          ph_wdata.zone     = lo_zone;
          inc_en            = 1'b1;
          inc_zone          = lo_zone;
        end
      end
      MODE_MOVE: begin
        if (pend_vld_r && rd_ent.zone == hi_zone) begin
          ph_we             = 1'b1;
          ph_wdata.unplaced = 1'b0;
          ph_wdata.zone     = lo_zone;
          inc_en            = 1'b1;
          inc_zone          = lo_zone;
          dec_en            = 1'b1;
        end
      end
      MODE_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int z = 0; z < MAX_ZONES; z++) begin
      if (cmd.load_last) begin
        tally_nxt[z] = '0;
      end else begin
        tally_nxt[z] = tally_r[z];
        if (inc_en && inc_zone == ZONE_W'(z)) begin
          tally_nxt[z] = tally_nxt[z] + CW'(1);
        end
        if (dec_en && dec_zone == ZONE_W'(z)) begin
          tally_nxt[z] = tally_nxt[z] - CW'(1);
        end
      end
    end
  end

  always_comb begin
    if (cmd.load_we) begin
      mem_we             = room;
      mem_waddr          = cnt_r[AW-1:0];
      mem_wdata.unplaced = !in_data.zone_known;
      mem_wdata.zone     = in_data.cur_zone;
    end else begin
      mem_we    = ph_we;
      mem_waddr = pend_addr_r;
      mem_wdata = ph_wdata;
    end
  end

  bza_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_item_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.rd_issue),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r   <= ZC_W'(1);
      keep_current_r <= 1'b1;
      cnt_r          <= '0;
      scan_r         <= '0;
      pend_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int z = 0; z < MAX_ZONES; z++) begin
        tally_r[z] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ZONE_COUNT:   zone_count_r   <= cfg_wdata[ZC_W-1:0];
          CFG_KEEP_CURRENT: keep_current_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      for (int z = 0; z < MAX_ZONES; z++) begin
        tally_r[z] <= tally_nxt[z];
      end
      if (cmd.grp_done) begin
        cnt_r <= '0;
      end else if (cmd.load_we && room) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.scan_clr) begin
        scan_r     <= '0;
        pend_vld_r <= 1'b0;
      end else begin
        pend_vld_r <= cmd.rd_issue;
        if (cmd.rd_issue) begin
          scan_r <= scan_r + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      n_r    <= cnt_r + CW'(room);
      zc_r   <= zc_eff;
      keep_r <= keep_current_r;
    end
    if (cmd.rd_issue && !cmd.scan_clr) begin
      pend_addr_r <= scan_r[AW-1:0];
    end
    if (cmd.out_load) begin
      out_data_r.item_position <= POS_W'(pend_addr_r);
      out_data_r.assigned_zone <= rd_ent.zone;
      out_data_r.last_result   <= st.pend_last;
    end
  end

  assign st.scan_end  = (scan_r == n_r);
  assign st.pend_vld  = pend_vld_r;
  assign st.pend_hit  = (rd_ent.zone == hi_zone);
  assign st.pend_last = ({{(CW-AW){1'b0}}, pend_addr_r} == (n_r - CW'(1)));
  assign st.balanced  = ((hi_cnt - lo_cnt) <= CW'(1));
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/balanced_zone_assigner_top.sv @@
// Balanced zone assigner: loads a group of items, spreads them over zones, emits results.
// Loading takes one item per cycle; results appear only after the last item of a group.
// After the last item: a keep pass, a fill pass, then balance checks, each followed by a move
// (a rescan of the item RAM from the first item) until balanced, and a read and a write state per result.
// Throughput is set by the single read port of the item RAM and the move rescans.
// Reset (synchronous, rst_n low) idles the sequencer and clears tallies; no RAM clear pass.
`default_nettype none

module balanced_zone_assigner_top #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_ZONES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire bza_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      bza_pkg::out_item_t             out_data,
  input  wire logic                           cfg_we,
  input  wire logic [bza_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bza_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bza_pkg::*;

  bza_cmd_t    cmd;
  bza_status_t st;

  bza_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_item),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bza_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .MAX_ZONES (MAX_ZONES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sv/bza_chk.sv @@
// Port-level checks for the balanced zone assigner, bound to the top level.
`default_nettype none

module bza_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire bza_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bza_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new item is taken while a group is still emitting
  a_no_load_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> !in_ready)
    else $error("input ready while group results pending");

  // the final item of a group starts processing, so input closes
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_item |=> !in_ready)
    else $error("input still ready after last item");

  // reset drops the result channel
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind balanced_zone_assigner_top bza_chk u_bza_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ bench/tb_balanced_zone_assigner_top.sv @@
// Self-checking bench for balanced_zone_assigner_top: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb_balanced_zone_assigner_top;
  import bza_pkg::*;

  localparam int GROUP_MAX    = 64;
  localparam int ZONES_MAX    = 8;
  localparam int ITEM_TARGET  = 470;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor copies of the registers and of the group being loaded
  logic [CFG_DATA_W-1:0] zone_count_r;
  logic                  keep_current_r;
  logic [ZONE_W-1:0]     grp_zone [GROUP_MAX];
  logic                  grp_known [GROUP_MAX];
  int                    grp_len;
  int                    zone_load [ZONES_MAX];

  out_item_t             zone_results_q [$];
  int                    errors;
  int                    items_sent;
  bit                    quiet;
  int                    rx_hold;
  int                    rx_stall;

  balanced_zone_assigner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int fewest_zone(input int zc);
    int best;
    best = 0;
    for (int z = 1; z < zc; z++)
      if (zone_load[z] < zone_load[best]) best = z;
    return best;
  endfunction

  function automatic int fullest_zone(input int zc);
    int best;
    best = 0;
    for (int z = 1; z < zc; z++)
      if (zone_load[z] > zone_load[best]) best = z;
    return best;
  endfunction

  // place the stored group, balance it and queue one result per item
  function automatic void assign_zones();
    logic      unplaced [GROUP_MAX];
    int        zc;
    int        lo;
    int        hi;
    out_item_t r;
    zc = (zone_count_r == 0) ? 1 :
         (zone_count_r > ZONES_MAX) ? ZONES_MAX : int'(zone_count_r);
    foreach (zone_load[z]) zone_load[z] = 0;
    for (int i = 0; i < grp_len; i++) begin
      if (keep_current_r && grp_known[i] && grp_zone[i] < zc) begin
        zone_load[grp_zone[i]]++;
        unplaced[i] = 1'b0;
      end else begin
        unplaced[i] = 1'b1;
      end
    end
    for (int i = 0; i < grp_len; i++) begin
      if (unplaced[i]) begin
        lo = fewest_zone(zc);
        grp_zone[i] = lo[ZONE_W-1:0];
        zone_load[lo]++;
      end
    end
    forever begin
      lo = fewest_zone(zc);
      hi = fullest_zone(zc);
      if (zone_load[hi] - zone_load[lo] <= 1) break;
      // first item in load order leaves the fullest zone
      for (int i = 0; i < grp_len; i++) begin
        if (grp_zone[i] == hi) begin
          grp_zone[i] = lo[ZONE_W-1:0];
          zone_load[hi]--;
          zone_load[lo]++;
          break;
        end
      end
    end
    for (int i = 0; i < grp_len; i++) begin
      r.item_position = i[POS_W-1:0];
      r.assigned_zone = grp_zone[i];
      r.last_result   = (i == grp_len - 1);
      zone_results_q.insert(zone_results_q.size(), r);
    end
  endfunction

  function automatic void note_item(input in_item_t it);
    if (grp_len < GROUP_MAX) begin
      grp_zone[grp_len]  = it.cur_zone;
      grp_known[grp_len] = it.zone_known;
      grp_len++;
    end
    if (it.last_item) begin
      assign_zones();
      grp_len = 0;
    end
  endfunction

  // called at a falling edge; returns at a falling edge with in_valid low
  task automatic send_item(input logic [ZONE_W-1:0] zone, input logic known,
                           input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) repeat (gap) @(negedge clk);
    in_data.cur_zone   = zone;
    in_data.zone_known = known;
    in_data.last_item  = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    note_item(in_data);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_group(input int n, input bit clustered);
    logic [ZONE_W-1:0] base;
    base = ZONE_W'($urandom_range(0, 7));
    for (int i = 0; i < n; i++) begin
      if (clustered)
        send_item(base, 1'b1, i == n - 1);
      else
        send_item(ZONE_W'($urandom_range(0, 7)), $urandom_range(0, 3) != 0, i == n - 1);
    end
  endtask

  task automatic wait_idle();
    while (zone_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    case (addr)
      CFG_ZONE_COUNT:   zone_count_r   = data;
      CFG_KEEP_CURRENT: keep_current_r = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] zc, input logic keep);
    wait_idle();
    write_reg(CFG_ZONE_COUNT, zc);
    write_reg(CFG_KEEP_CURRENT, {{(CFG_DATA_W-1){1'b0}}, keep});
  endtask

  // registers at reset value, then kept zones, out-of-range zones, unknown zones
  task automatic test_keep_current();
    send_item(3'd5, 1'b1, 1'b0);
    send_item(3'd0, 1'b0, 1'b1);
    set_config(4'd4, 1'b1);
    send_item(3'd7, 1'b1, 1'b0);
    send_item(3'd0, 1'b1, 1'b0);
    send_item(3'd3, 1'b1, 1'b0);
    send_item(3'd4, 1'b1, 1'b0);
    send_item(3'd2, 1'b0, 1'b0);
    send_item(3'd5, 1'b0, 1'b1);
    set_config(4'd8, 1'b1);
    send_item(3'd7, 1'b1, 1'b1);
  endtask

  task automatic test_zone_count_limits();
    set_config(4'd0, 1'b0);
    send_item(3'd6, 1'b1, 1'b0);
    send_item(3'd1, 1'b0, 1'b0);
    send_item(3'd0, 1'b1, 1'b1);
    // all items kept in one zone forces a run of moves
    set_config(4'd15, 1'b1);
    repeat (3) send_item(3'd0, 1'b1, 1'b0);
    send_item(3'd0, 1'b1, 1'b1);
  endtask

  task automatic test_reassign_all();
    set_config(4'd3, 1'b0);
    send_item(3'd2, 1'b1, 1'b0);
    send_item(3'd2, 1'b1, 1'b0);
    send_item(3'd1, 1'b1, 1'b1);
  endtask

  // a group past the item limit (extra items, the final one too, are dropped), then a full group
  task automatic test_group_overflow();
    set_config(4'd8, 1'b1);
    quiet = 1'b1;
    for (int i = 0; i < 70; i++) send_item(3'd0, 1'b1, i == 69);
    quiet = 1'b0;
    set_config(4'd5, 1'b0);
    send_group(64, 1'b0);
  endtask

  // receiver stops for a long stretch while a second group is offered
  task automatic test_input_backpressure();
    set_config(4'd6, 1'b1);
    rx_hold = 400;
    quiet = 1'b1;
    send_group(20, 1'b1);
    send_group(20, 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random_groups();
    int                    r;
    logic [CFG_DATA_W-1:0] zc;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      zc = (r == 0) ? '0 : (r == 1) ? CFG_DATA_W'($urandom_range(9, 15)) :
           CFG_DATA_W'($urandom_range(1, 8));
      set_config(zc, 1'($urandom_range(0, 1)));
      quiet = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        send_group((r < 85) ? $urandom_range(1, 12) :
                   (r < 97) ? $urandom_range(13, 40) : $urandom_range(60, 70),
                   $urandom_range(0, 3) == 0);
      end
      quiet = 1'b0;
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = 1'b1;
      rx_stall  = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (zone_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos %0d zone %0d",
                                  out_data.item_position, out_data.assigned_zone));
      end else begin
        want = zone_results_q.pop_front();
        if (out_data.item_position !== want.item_position)
          report_mismatch($sformatf("item_position got %0d want %0d",
                                    out_data.item_position, want.item_position));
        if (out_data.assigned_zone !== want.assigned_zone)
          report_mismatch($sformatf("assigned_zone got %0d want %0d (pos %0d)",
                                    out_data.assigned_zone, want.assigned_zone,
                                    want.item_position));
        if (out_data.last_result !== want.last_result)
          report_mismatch($sformatf("last_result got %0b want %0b (pos %0d)",
                                    out_data.last_result, want.last_result,
                                    want.item_position));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_balanced_zone_assigner_top failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    zone_count_r   = 4'd1;
    keep_current_r = 1'b1;
    grp_len        = 0;
    errors         = 0;
    items_sent     = 0;
    quiet          = 1'b0;
    rx_hold        = 0;
    rx_stall       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_keep_current();
    test_zone_count_limits();
    test_reassign_all();
    test_group_overflow();
    test_input_backpressure();
    test_random_groups();

    while (zone_results_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && zone_results_q.size() == 0)
      $display("tb_balanced_zone_assigner_top passed");
    else
      $display("tb_balanced_zone_assigner_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bza_pkg.sv
sv/bza_ram.sv
sv/bza_ctrl.sv
sv/bza_dp.sv
sv/balanced_zone_assigner_top.sv
sv/bza_chk.sv
bench/tb_balanced_zone_assigner_top.sv
